>>> rtl/mau_pkg.sv
// mau_pkg: types, codes and constants of the modular arithmetic unit
// used by mau_div and modular_arithmetic_unit, depends on nothing
package mau_pkg;

  localparam int unsigned MOD_W = 32;
  localparam int unsigned RES_W = 31;
  localparam int unsigned DIV_W = 64;
  localparam int unsigned T_W   = 34;
  localparam logic [MOD_W-1:0] MOD_MAX = 32'h8000_0000;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_NEG = 3'd4,
    KIND_INV = 3'd5,
    KIND_POW = 3'd6,
    KIND_RED = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_RED,
    S_RWAIT,
    S_POW,
    S_INV,
    S_TMUL,
    S_TSUB,
    S_INVEND,
    S_DONE
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [30:0]        operand_a;
    logic [30:0]        operand_b;
    logic [63:0]        exponent;
    logic signed [63:0] raw_integer;
  } in_t;

  typedef struct packed {
    logic [30:0] result;
    logic        error;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [MOD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [MOD_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/mau_div.sv
// mau_div: restoring divider, one quotient bit per cycle
// 64-bit dividend by 32-bit divisor, uses mau_pkg
module mau_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mau_pkg::div_req_t  req_i,
  output mau_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned CNT_W = $clog2(mau_pkg::DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mau_pkg::DIV_W - 1);

  logic                      busy_q;
  logic                      done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [mau_pkg::DIV_W-1:0] dvd_q;
  logic [mau_pkg::MOD_W-1:0] rem_q;
  logic [mau_pkg::MOD_W-1:0] dsr_q;
  logic [mau_pkg::MOD_W:0]   trial;
  logic [mau_pkg::MOD_W:0]   diff;
  logic                      ge;

  assign trial = {rem_q, dvd_q[mau_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_LAST);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[mau_pkg::MOD_W-1:0] : trial[mau_pkg::MOD_W-1:0];
      dvd_q <= {dvd_q[mau_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a run");

  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.divisor != '0)
    else $error("divide by zero");

endmodule

>>> rtl/modular_arithmetic_unit.sv
// modular_arithmetic_unit: top level, sequencer around a shared multiplier and divider
// uses mau_pkg and mau_div
//
//  channel | dir | handshake                | beat
//  in      | in  | in_valid_i / in_stall_o  | mau_pkg::in_t
//  out     | out | out_valid_o / out_stall_i| mau_pkg::out_t
//  cfg     | in  | cfg_we_i                 | cfg_wdata_i, modulus
//
// add, sub, neg and operand errors skip the divider; mul and reduce use it
// each modular multiply is the S_MUL state followed by a full divider run
// pow takes up to 2*EXP_BITS multiplies, inverse one divider run per euclid step
// reset sets the modulus to one; the input stalls while an item is in work
// a waiting output beat does not block the next input beat
module modular_arithmetic_unit #(
  parameter int unsigned EXP_BITS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  mau_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output mau_pkg::out_t             out_data_o,
  input  logic                      cfg_we_i,
  input  logic [mau_pkg::MOD_W-1:0] cfg_wdata_i
);

  localparam int unsigned MW = mau_pkg::MOD_W;
  localparam int unsigned TW = mau_pkg::T_W;

  mau_pkg::state_e state_q, state_d;

  logic [MW-1:0]            mod_q;
  logic                     out_valid_q;
  mau_pkg::out_t            out_q;
  mau_pkg::kind_e           kind_q;
  logic [30:0]              a_q;
  logic [EXP_BITS-1:0]      e_q;
  logic                     err_q;
  logic [30:0]              res_q;
  logic                     euclid_q;
  logic                     neg_q;
  logic                     pow_sq_q;
  logic [MW-1:0]            acc_q;
  logic [MW-1:0]            base_q;
  logic [MW-1:0]            r0_q;
  logic [MW-1:0]            r1_q;
  logic signed [TW-1:0]     t0_q;
  logic signed [TW-1:0]     t1_q;
  logic signed [TW-1:0]     tp_q;
  logic signed [TW-1:0]     mx_q;
  logic signed [TW-1:0]     my_q;
  logic [mau_pkg::DIV_W-1:0] dvd_q;
  logic [MW-1:0]            dsr_q;

  logic signed [2*TW-1:0]   mult;
  logic                     in_acc;
  logic                     load;
  logic                     a_ge;
  logic                     b_ge;
  logic                     err_in;
  logic [MW-1:0]            quick;
  logic [MW-1:0]            sum;
  logic [TW-1:0]            tadd;
  logic [TW-1:0]            tfix;
  logic [TW-1:0]            m_ext;
  logic [MW-1:0]            red_res;
  mau_pkg::div_req_t        div_req;
  mau_pkg::div_rsp_t        div_rsp;

  mau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign div_req.start    = state_q == mau_pkg::S_RED;
  assign div_req.dividend = dvd_q;
  assign div_req.divisor  = dsr_q;

  assign mult   = mx_q * my_q;
  assign in_acc = in_valid_i && (state_q == mau_pkg::S_IDLE);
  assign load   = !(out_valid_q && out_stall_i);
  assign in_stall_o = state_q != mau_pkg::S_IDLE;

  assign a_ge   = {1'b0, in_data_i.operand_a} >= mod_q;
  assign b_ge   = {1'b0, in_data_i.operand_b} >= mod_q;
  assign err_in = (in_data_i.kind != mau_pkg::KIND_RED && a_ge) ||
                  (in_data_i.kind inside {mau_pkg::KIND_ADD, mau_pkg::KIND_SUB,
                                          mau_pkg::KIND_MUL, mau_pkg::KIND_DIV} && b_ge);

  assign sum = {1'b0, in_data_i.operand_a} + {1'b0, in_data_i.operand_b};

  always_comb begin
    case (in_data_i.kind)
      mau_pkg::KIND_ADD: quick = (sum >= mod_q) ? sum - mod_q : sum;
      mau_pkg::KIND_SUB: begin
        if (in_data_i.operand_a >= in_data_i.operand_b) begin
          quick = {1'b0, in_data_i.operand_a} - {1'b0, in_data_i.operand_b};
        end else begin
          quick = {1'b0, in_data_i.operand_a} + (mod_q - {1'b0, in_data_i.operand_b});
        end
      end
      mau_pkg::KIND_NEG: quick = (in_data_i.operand_a == '0) ? '0 :
                                 mod_q - {1'b0, in_data_i.operand_a};
      default:           quick = '0;
    endcase
  end

  assign m_ext = {{(TW-MW){1'b0}}, mod_q};
  assign tadd  = t0_q[TW-1] ? TW'(t0_q) + m_ext : TW'(t0_q);
  assign tfix  = (tadd >= m_ext) ? tadd - m_ext : tadd;

  assign red_res = neg_q ? ((div_rsp.rem == '0) ? '0 : mod_q - div_rsp.rem) : div_rsp.rem;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mau_pkg::S_IDLE: begin
        if (in_acc) begin
          if (err_in) begin
            state_d = mau_pkg::S_DONE;
          end else begin
            case (in_data_i.kind)
              mau_pkg::KIND_MUL: state_d = mau_pkg::S_MUL;
              mau_pkg::KIND_DIV: state_d = mau_pkg::S_INV;
              mau_pkg::KIND_INV: state_d = mau_pkg::S_INV;
              mau_pkg::KIND_POW: state_d = mau_pkg::S_POW;
              mau_pkg::KIND_RED: state_d = mau_pkg::S_RED;
              default:           state_d = mau_pkg::S_DONE;
            endcase
          end
        end
      end
      mau_pkg::S_MUL:  state_d = mau_pkg::S_RED;
      mau_pkg::S_RED:  state_d = mau_pkg::S_RWAIT;
      mau_pkg::S_RWAIT: begin
        if (div_rsp.done) begin
          if (euclid_q) begin
            state_d = mau_pkg::S_TMUL;
          end else if (kind_q == mau_pkg::KIND_POW) begin
            state_d = pow_sq_q ? mau_pkg::S_POW : mau_pkg::S_MUL;
          end else begin
            state_d = mau_pkg::S_DONE;
          end
        end
      end
      mau_pkg::S_POW:  state_d = (e_q == '0) ? mau_pkg::S_DONE : mau_pkg::S_MUL;
      mau_pkg::S_INV:  state_d = (r1_q == '0) ? mau_pkg::S_INVEND : mau_pkg::S_RED;
      mau_pkg::S_TMUL: state_d = mau_pkg::S_TSUB;
      mau_pkg::S_TSUB: state_d = mau_pkg::S_INV;
      mau_pkg::S_INVEND: begin
        if (r0_q != MW'(1) || kind_q == mau_pkg::KIND_INV) begin
          state_d = mau_pkg::S_DONE;
        end else begin
          state_d = mau_pkg::S_MUL;
        end
      end
      mau_pkg::S_DONE: if (load) state_d = mau_pkg::S_IDLE;
      default: state_d = mau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mau_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      mod_q       <= MW'(1);
    end else begin
      state_q <= state_d;
      if (state_q == mau_pkg::S_DONE && load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        if (cfg_wdata_i == '0) begin
          mod_q <= MW'(1);
        end else if (cfg_wdata_i > mau_pkg::MOD_MAX) begin
          mod_q <= mau_pkg::MOD_MAX;
        end else begin
          mod_q <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mau_pkg::S_DONE && load) begin
      out_q.result <= err_q ? '0 : res_q;
      out_q.error  <= err_q;
    end
    case (state_q)
      mau_pkg::S_IDLE: begin
        if (in_acc) begin
          kind_q   <= in_data_i.kind;
          a_q      <= in_data_i.operand_a;
          e_q      <= in_data_i.exponent[EXP_BITS-1:0];
          err_q    <= err_in;
          res_q    <= quick[30:0];
          euclid_q <= 1'b0;
          neg_q    <= in_data_i.raw_integer[63];
          acc_q    <= (mod_q == MW'(1)) ? '0 : MW'(1);
          base_q   <= {1'b0, in_data_i.operand_a};
          r0_q     <= mod_q;
          r1_q     <= (in_data_i.kind == mau_pkg::KIND_DIV) ?
                      {1'b0, in_data_i.operand_b} : {1'b0, in_data_i.operand_a};
          t0_q     <= '0;
          t1_q     <= TW'(1);
          mx_q     <= {3'b000, in_data_i.operand_a};
          my_q     <= {3'b000, in_data_i.operand_b};
          dvd_q    <= in_data_i.raw_integer[63] ? 64'(-in_data_i.raw_integer) :
                      64'(in_data_i.raw_integer);
          dsr_q    <= mod_q;
        end
      end
      mau_pkg::S_MUL: begin
        dvd_q    <= mult[mau_pkg::DIV_W-1:0];
        dsr_q    <= mod_q;
        euclid_q <= 1'b0;
      end
      mau_pkg::S_RWAIT: begin
        if (div_rsp.done) begin
          if (euclid_q) begin
            r0_q <= r1_q;
            r1_q <= div_rsp.rem;
            mx_q <= {2'b00, div_rsp.quot[MW-1:0]};
            my_q <= t1_q;
          end else if (kind_q == mau_pkg::KIND_POW) begin
            if (pow_sq_q) begin
              base_q <= div_rsp.rem;
              e_q    <= e_q >> 1;
            end else begin
              acc_q    <= div_rsp.rem;
              mx_q     <= {2'b00, base_q};
              my_q     <= {2'b00, base_q};
              pow_sq_q <= 1'b1;
            end
          end else if (kind_q == mau_pkg::KIND_RED) begin
            res_q <= red_res[30:0];
          end else begin
            res_q <= div_rsp.rem[30:0];
          end
        end
      end
      mau_pkg::S_POW: begin
        res_q    <= acc_q[30:0];
        mx_q     <= e_q[0] ? {2'b00, acc_q} : {2'b00, base_q};
        my_q     <= {2'b00, base_q};
        pow_sq_q <= !e_q[0];
      end
      mau_pkg::S_INV: begin
        dvd_q    <= {{(mau_pkg::DIV_W-MW){1'b0}}, r0_q};
        dsr_q    <= r1_q;
        euclid_q <= 1'b1;
      end
      mau_pkg::S_TMUL: tp_q <= mult[TW-1:0];
      mau_pkg::S_TSUB: begin
        t0_q <= t1_q;
        t1_q <= t0_q - tp_q;
      end
      mau_pkg::S_INVEND: begin
        if (r0_q != MW'(1)) begin
          err_q <= 1'b1;
        end else begin
          res_q <= tfix[30:0];
          mx_q  <= {3'b000, a_q};
          my_q  <= tfix;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_q != '0 && mod_q <= mau_pkg::MOD_MAX)
    else $error("modulus out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.result == '0)
    else $error("error beat with nonzero result");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == mau_pkg::S_RWAIT)
    else $error("divider result outside wait state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != mau_pkg::S_IDLE)
    else $error("accepted beat not taken into work");

endmodule
